[hw/rtl/tallp_pkg.sv]
// Shared types and constants for the three-axis leaky low-pass filter.
`timescale 1ns / 1ps

package tallp_pkg;

    localparam int NUM_AXES  = 3;
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 32;
    localparam int TC_W      = 15;
    localparam int CNT_W     = $clog2(ACC_W);
    localparam int REM_W     = TC_W + 1;

    localparam logic [TC_W-1:0] TC_RESET = TC_W'(8);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [TC_W-1:0]            t_tc;

    typedef struct packed {
        logic start;
        logic take;
    } t_lane_ctl;

endpackage

[hw/rtl/three_axis_leaky_lowpass_core.sv]
// Top level of the three-axis leaky low-pass filter.
`timescale 1ns / 1ps
// Exponential moving average over three signed 16-bit axes.
// Input channel: i_raw_x/y/z with i_valid; the core drives o_stall. A transaction is
// taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_filtered_x/y/z with o_valid; the receiver drives i_stall, and
// the result holds steady while stalled.
// Each axis has its own lane with a 32-bit accumulator and a one-bit-per-cycle
// restoring divider; the three lanes run in lockstep and the output stage
// collects their quotients. The divider's 32 steps are followed by an update
// step and a hand-off to the output register, and a new input is taken once the
// previous result has moved to the output register.
// A finished result may wait in the output register while the next input
// transaction is already being processed; if that wait lasts past the division,
// the lanes hold their results and o_stall stays high.
// The user must write the time constant through i_cfg_wr_en/i_cfg_wr_data only
// while idle; the block itself does not enforce this. A value of zero acts as one.
// Synchronous reset clears the accumulators, sets the time constant to 8 and
// empties the output register. No clearing pass is needed.

module three_axis_leaky_lowpass_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_raw_x,
    input  logic signed [15:0]   i_raw_y,
    input  logic signed [15:0]   i_raw_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_filtered_x,
    output logic signed [15:0]   o_filtered_y,
    output logic signed [15:0]   o_filtered_z,
    input  logic                 i_cfg_wr_en,
    input  logic [14:0]          i_cfg_wr_data
);

    tallp_pkg::t_tc       r_tc;
    logic                 r_busy;
    tallp_pkg::t_tc       divisor;
    tallp_pkg::t_lane_ctl lane_ctl;
    logic                 accept;
    logic                 take;
    logic [tallp_pkg::NUM_AXES-1:0] done;
    tallp_pkg::t_sample   raw  [tallp_pkg::NUM_AXES];
    tallp_pkg::t_sample   quot [tallp_pkg::NUM_AXES];
    tallp_pkg::t_sample   filt [tallp_pkg::NUM_AXES];

    assign accept  = i_valid && !r_busy;
    assign o_stall = r_busy;
    assign divisor = (r_tc == '0) ? tallp_pkg::t_tc'(1) : r_tc;

    assign lane_ctl.start = accept;
    assign lane_ctl.take  = take;

    assign raw[0] = i_raw_x;
    assign raw[1] = i_raw_y;
    assign raw[2] = i_raw_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc   <= tallp_pkg::TC_RESET;
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tc <= i_cfg_wr_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < tallp_pkg::NUM_AXES; g++) begin : g_lane
        tallp_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_raw     (raw[g]),
            .i_divisor (divisor),
            .o_done    (done[g]),
            .o_quot    (quot[g])
        );
    end

    tallp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_done  (done),
        .i_quot  (quot),
        .i_stall (i_stall),
        .o_take  (take),
        .o_valid (o_valid),
        .o_filt  (filt)
    );

    assign o_filtered_x = filt[0];
    assign o_filtered_y = filt[1];
    assign o_filtered_z = filt[2];

endmodule

[hw/rtl/tallp_lane.sv]
// One axis lane: accumulator, bit-serial divider, saturation and update.
`timescale 1ns / 1ps

module tallp_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tallp_pkg::t_lane_ctl i_ctl,
    input  tallp_pkg::t_sample  i_raw,
    input  tallp_pkg::t_tc      i_divisor,
    output logic                o_done,
    output tallp_pkg::t_sample  o_quot
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN,
        S_HOLD
    } t_state;

    localparam logic signed [tallp_pkg::ACC_W+1:0] ACC_MAX =
        {3'b000, {(tallp_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [tallp_pkg::ACC_W+1:0] ACC_MIN =
        {3'b111, {(tallp_pkg::ACC_W-1){1'b0}}};

    t_state                              r_state, n_state;
    tallp_pkg::t_acc                     r_acc, n_acc;
    tallp_pkg::t_sample                  r_raw, n_raw;
    tallp_pkg::t_tc                      r_div, n_div;
    logic [tallp_pkg::REM_W-1:0]         r_rem, n_rem;
    logic [tallp_pkg::ACC_W-1:0]         r_dvd, n_dvd;
    logic [tallp_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic                                r_neg, n_neg;
    tallp_pkg::t_sample                  r_quot, n_quot;

    logic [tallp_pkg::REM_W-1:0]         trial;
    logic                                qbit;
    tallp_pkg::t_sample                  q_sat;
    logic signed [tallp_pkg::ACC_W+1:0]  sum;

    always_comb begin
        trial = {r_rem[tallp_pkg::REM_W-2:0], r_dvd[tallp_pkg::ACC_W-1]};
        qbit  = (trial >= {1'b0, r_div});

        if (r_neg) begin
            if ((|r_dvd[tallp_pkg::ACC_W-1:tallp_pkg::SAMPLE_W]) ||
                (r_dvd[tallp_pkg::SAMPLE_W-1] && (|r_dvd[tallp_pkg::SAMPLE_W-2:0]))) begin
                q_sat = {1'b1, {(tallp_pkg::SAMPLE_W-1){1'b0}}};
            end else begin
                q_sat = tallp_pkg::t_sample'(-r_dvd[tallp_pkg::SAMPLE_W-1:0]);
            end
        end else begin
            if (|r_dvd[tallp_pkg::ACC_W-1:tallp_pkg::SAMPLE_W-1]) begin
                q_sat = {1'b0, {(tallp_pkg::SAMPLE_W-1){1'b1}}};
            end else begin
                q_sat = tallp_pkg::t_sample'(r_dvd[tallp_pkg::SAMPLE_W-1:0]);
            end
        end

        sum = (tallp_pkg::ACC_W+2)'(r_acc) + (tallp_pkg::ACC_W+2)'(r_raw)
            - (tallp_pkg::ACC_W+2)'(q_sat);

        n_state = r_state;
        n_acc   = r_acc;
        n_raw   = r_raw;
        n_div   = r_div;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_quot  = r_quot;

        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_raw   = i_raw;
                    n_div   = i_divisor;
                    n_neg   = r_acc[tallp_pkg::ACC_W-1];
                    n_dvd   = r_acc[tallp_pkg::ACC_W-1] ? (-r_acc) : r_acc;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = qbit ? (trial - {1'b0, r_div}) : trial;
                n_dvd = {r_dvd[tallp_pkg::ACC_W-2:0], qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tallp_pkg::CNT_W'(tallp_pkg::ACC_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_quot = q_sat;
                if (sum > ACC_MAX) begin
                    n_acc = tallp_pkg::t_acc'(ACC_MAX);
                end else if (sum < ACC_MIN) begin
                    n_acc = tallp_pkg::t_acc'(ACC_MIN);
                end else begin
                    n_acc = tallp_pkg::t_acc'(sum);
                end
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
        end
        r_raw  <= n_raw;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_done = (r_state == S_HOLD);
    assign o_quot = r_quot;

endmodule

[hw/rtl/tallp_merge.sv]
// Output stage that gathers the lane results into one output transaction.
`timescale 1ns / 1ps

module tallp_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [tallp_pkg::NUM_AXES-1:0] i_done,
    input  tallp_pkg::t_sample  i_quot [tallp_pkg::NUM_AXES],
    input  logic                i_stall,
    output logic                o_take,
    output logic                o_valid,
    output tallp_pkg::t_sample  o_filt [tallp_pkg::NUM_AXES]
);

    logic               r_valid;
    tallp_pkg::t_sample r_filt [tallp_pkg::NUM_AXES];

    assign o_take = (&i_done) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (o_take) begin
            r_filt <= i_quot;
        end
    end

    assign o_valid = r_valid;
    assign o_filt  = r_filt;

endmodule

[hw/rtl/tallp_chk.sv]
// Port-level checker for the three-axis leaky low-pass filter and its bind.
`timescale 1ns / 1ps

module tallp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_filtered_x,
    input logic signed [15:0] o_filtered_y,
    input logic signed [15:0] o_filtered_z
);

    // An accepted input transaction blocks further input until its result moves out.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not blocked after accepted transaction");

    // No result can appear in the cycle right after an input transaction.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !$rose(o_valid))
        else $error("result appeared too early");

    // The input side reopens exactly when a result enters the output register.
    a_release_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid)
        else $error("input released without a result");

    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_filtered_x) &&
            $stable(o_filtered_y) && $stable(o_filtered_z)))
        else $error("stalled output changed");

endmodule

bind three_axis_leaky_lowpass_core tallp_chk u_tallp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_filtered_x (o_filtered_x),
    .o_filtered_y (o_filtered_y),
    .o_filtered_z (o_filtered_z)
);
